>>> hw/rtl/gswg_pkg.sv
// Shared constants and types for the grouped softmax with gradient block.
package gswg_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int MAX_GROUPS_DEF   = 64;

    localparam int VAL_W  = 16;
    localparam int GRP_W  = 6;
    localparam int RES_W  = 32;
    localparam int E_W    = 17;
    localparam int RCP_W  = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_PASS_DIRECTION = 1'b0;

    localparam logic [31:0] LOG2E_Q16 = 32'd94548;
    localparam logic [31:0] EXP_C1    = 32'd43024;
    localparam logic [31:0] EXP_C2    = 32'd10256;
    localparam logic [31:0] EPS_Q16   = 32'd7;

    typedef enum logic [1:0] {
        SH_0,
        SH_8,
        SH_16
    } shift_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        shift_t      sh;
        logic        neg;
    } mul_req_t;

endpackage

>>> hw/rtl/gswg_mul.sv
// Shared 32x32 multiplier with registered product, shift and signed saturation.
module gswg_mul (
    input  logic                clk,
    input  gswg_pkg::mul_req_t  req,
    output logic [63:0]         prod,
    output logic signed [31:0]  sat_out
);
    import gswg_pkg::*;

    logic [63:0] prod_reg;
    shift_t      sh_reg;
    logic        neg_reg;
    logic [63:0] q;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
        sh_reg   <= req.sh;
        neg_reg  <= req.neg;
    end

    always_comb
    begin
        case (sh_reg)
            SH_8:    q = prod_reg >> 8;
            SH_16:   q = prod_reg >> 16;
            default: q = prod_reg;
        endcase
        if (neg_reg)
        begin
            if (q > 64'h0000_0000_8000_0000)
                sat_out = 32'sh8000_0000;
            else
                sat_out = 32'(-q);
        end
        else
        begin
            if (q > 64'h0000_0000_7FFF_FFFF)
                sat_out = 32'sh7FFF_FFFF;
            else
                sat_out = 32'(q);
        end
    end

    assign prod = prod_reg;

endmodule

>>> hw/rtl/gswg_div.sv
// Restoring divider forming floor(2^32 / divisor), one quotient bit per cycle.
module gswg_div #(
    parameter int DW = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [DW-1:0]                   divisor,
    output logic                            done,
    output logic [gswg_pkg::RCP_W-1:0]      quotient
);
    import gswg_pkg::*;

    localparam int STEPS = RCP_W + 1;
    localparam int NW    = $clog2(STEPS + 1);

    logic          run_reg;
    logic [NW-1:0] cnt_reg;
    logic          done_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] rem_reg;
    logic [RCP_W-1:0] q_reg;
    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_sub;

    assign rem_sh  = {rem_reg, (cnt_reg == NW'(STEPS))};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == NW'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= NW'(STEPS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - NW'(1);
                if (cnt_reg == NW'(1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            q_reg   <= {q_reg[RCP_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> hw/rtl/gswg_core.sv
// Element stores, group tables and the sequencer driving the shared multiplier and divider.
module gswg_core #(
    parameter int MAX_ELEMENTS = gswg_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_GROUPS   = gswg_pkg::MAX_GROUPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gswg_pkg::VAL_W-1:0]   value,
    input  logic signed [gswg_pkg::VAL_W-1:0]   upstream_gradient,
    input  logic [gswg_pkg::GRP_W-1:0]          group_index,
    input  logic                                last_element,
    input  logic                                pass_direction,
    output logic                                busy,
    output logic                                result_valid,
    output logic signed [gswg_pkg::RES_W-1:0]   result_value,
    output logic                                last_result
);
    import gswg_pkg::*;

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SW = E_W + IW;
    localparam int DW = SW + 1;
    localparam int GRP_CODES = 2 ** GRP_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR,
        ST_E_RD, ST_E0, ST_E1, ST_E2, ST_E3, ST_E4,
        ST_D_RD, ST_D_GO, ST_D_WAIT,
        ST_B_RD, ST_B_RD2, ST_B1, ST_B2, ST_B3, ST_B4,
        ST_O_RD, ST_O_RD2, ST_OF, ST_OB1, ST_OB2, ST_EMIT
    } state_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -33'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    state_t                 state_reg;
    logic [CW-1:0]          cnt_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic [IW-1:0]          idx_reg;
    logic [GW-1:0]          gidx_reg;
    logic [8:0]             n_reg;
    logic [15:0]            f_reg;
    logic [15:0]            ff_reg;
    logic [15:0]            t1_reg;
    logic                   valid_reg;
    logic signed [RES_W-1:0] res_reg;
    logic                   last_reg;

    logic signed [VAL_W-1:0] value_mem [MAX_ELEMENTS];
    logic signed [VAL_W-1:0] grad_mem  [MAX_ELEMENTS];
    logic [GW-1:0]          group_mem [MAX_ELEMENTS];
    logic [E_W-1:0]         e_mem     [MAX_ELEMENTS];
    logic [SW-1:0]          sum_mem   [MAX_GROUPS];
    logic signed [31:0]     gs_mem    [MAX_GROUPS];
    logic [RCP_W-1:0]       rcp_mem   [MAX_GROUPS];

    logic signed [VAL_W-1:0] v_q;
    logic signed [VAL_W-1:0] g_q;
    logic [GW-1:0]          grp_q;
    logic [E_W-1:0]         e_q;
    logic [SW-1:0]          sum_q;
    logic signed [31:0]     gs_q;
    logic [RCP_W-1:0]       rcp_q;

    logic [GW-1:0]          fold_tab [GRP_CODES];

    logic                   accept;
    logic                   full;
    logic                   idx_last;
    logic                   gidx_last;
    logic [16:0]            m_full;
    logic [16:0]            p;
    logic [E_W-1:0]         e_new;
    logic [SW-1:0]          sum_new;
    logic signed [31:0]     gs_new;
    logic signed [31:0]     inner;
    logic [15:0]            g_mag;
    logic [GW-1:0]          sum_addr;
    logic                   sum_we;
    logic [SW-1:0]          sum_wd;
    logic [GW-1:0]          sum_wa;
    logic                   gs_we;
    logic signed [31:0]     gs_wd;
    logic [GW-1:0]          gs_wa;

    mul_req_t               mreq;
    logic [63:0]            mul_prod;
    logic signed [31:0]     mul_sat;
    logic                   div_start;
    logic                   div_done;
    logic [RCP_W-1:0]       div_q;

    for (genvar k = 0; k < GRP_CODES; k++)
    begin : g_fold
        assign fold_tab[k] = GW'(k % MAX_GROUPS);
    end

    gswg_mul u_mul (
        .clk     (clk),
        .req     (mreq),
        .prod    (mul_prod),
        .sat_out (mul_sat)
    );

    gswg_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (DW'(sum_q) + DW'(EPS_Q16)),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy      = state_reg != ST_IDLE;
    assign accept    = start && !busy;
    assign full      = cnt_reg == CW'(MAX_ELEMENTS);
    assign idx_last  = (CW'(idx_reg) + CW'(1)) == cnt_reg;
    assign gidx_last = gidx_reg == GW'(MAX_GROUPS - 1);
    assign div_start = state_reg == ST_D_GO;

    assign m_full  = {max_reg[VAL_W-1], max_reg} - {v_q[VAL_W-1], v_q};
    assign p       = 17'(32'd65536 - 32'(t1_reg) + 32'(mul_prod[31:16]));
    assign e_new   = (n_reg > 9'd31) ? '0 : E_W'(p >> n_reg[4:0]);
    assign sum_new = sum_q + SW'(e_new);
    assign gs_new  = sat33({gs_q[31], gs_q} - {mul_sat[31], mul_sat});
    assign inner   = sat33({gs_q[31], gs_q} + {mul_sat[31], mul_sat});
    assign g_mag   = g_q[VAL_W-1] ? 16'(-g_q) : 16'(g_q);

    always_comb
    begin
        mreq.a   = '0;
        mreq.b   = '0;
        mreq.sh  = SH_0;
        mreq.neg = 1'b0;
        case (state_reg)
            ST_E0:
            begin
                mreq.a = 32'(m_full[15:0]);
                mreq.b = LOG2E_Q16;
            end
            ST_E1:
            begin
                mreq.a = 32'(mul_prod[23:8]);
                mreq.b = 32'(mul_prod[23:8]);
            end
            ST_E2:
            begin
                mreq.a = EXP_C1;
                mreq.b = 32'(f_reg);
            end
            ST_E3:
            begin
                mreq.a = EXP_C2;
                mreq.b = 32'(ff_reg);
            end
            ST_B1:
            begin
                mreq.a   = 32'(g_mag);
                mreq.b   = 32'(e_q);
                mreq.sh  = SH_8;
                mreq.neg = g_q[VAL_W-1];
            end
            ST_B2, ST_B3:
            begin
                mreq.a   = mag32(mul_sat);
                mreq.b   = rcp_q;
                mreq.sh  = SH_16;
                mreq.neg = mul_sat[31];
            end
            ST_OF:
            begin
                mreq.a  = 32'(e_q);
                mreq.b  = rcp_q;
                mreq.sh = SH_16;
            end
            ST_OB1:
            begin
                mreq.a   = 32'(g_mag);
                mreq.b   = rcp_q;
                mreq.sh  = SH_8;
                mreq.neg = g_q[VAL_W-1];
            end
            ST_OB2:
            begin
                mreq.a   = mag32(inner);
                mreq.b   = 32'(e_q);
                mreq.sh  = SH_16;
                mreq.neg = inner[31];
            end
            default:
            begin
                mreq.a = '0;
            end
        endcase
    end

    always_comb
    begin
        sum_addr = (state_reg == ST_D_RD || state_reg == ST_D_GO || state_reg == ST_D_WAIT)
                   ? gidx_reg : grp_q;
        sum_we = 1'b0;
        sum_wa = grp_q;
        sum_wd = sum_new;
        gs_we  = 1'b0;
        gs_wa  = grp_q;
        gs_wd  = gs_new;
        case (state_reg)
            ST_CLR:
            begin
                sum_we = 1'b1;
                sum_wa = gidx_reg;
                sum_wd = '0;
                gs_we  = 1'b1;
                gs_wa  = gidx_reg;
                gs_wd  = '0;
            end
            ST_E4:
            begin
                sum_we = 1'b1;
            end
            ST_B4:
            begin
                gs_we = 1'b1;
            end
            default:
            begin
                sum_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            value_mem[cnt_reg[IW-1:0]] <= value;
            grad_mem[cnt_reg[IW-1:0]]  <= upstream_gradient;
            group_mem[cnt_reg[IW-1:0]] <= fold_tab[group_index];
        end
        if (state_reg == ST_E4)
            e_mem[idx_reg] <= e_new;
        if (sum_we)
            sum_mem[sum_wa] <= sum_wd;
        if (gs_we)
            gs_mem[gs_wa] <= gs_wd;
        if (state_reg == ST_D_WAIT && div_done)
            rcp_mem[gidx_reg] <= div_q;
        v_q   <= value_mem[idx_reg];
        g_q   <= grad_mem[idx_reg];
        grp_q <= group_mem[idx_reg];
        e_q   <= e_mem[idx_reg];
        sum_q <= sum_mem[sum_addr];
        gs_q  <= gs_mem[grp_q];
        rcp_q <= rcp_mem[grp_q];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            max_reg   <= '0;
            idx_reg   <= '0;
            gidx_reg  <= '0;
            n_reg     <= '0;
            f_reg     <= '0;
            ff_reg    <= '0;
            t1_reg    <= '0;
            valid_reg <= 1'b0;
            res_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!full)
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                            if (value > max_reg)
                                max_reg <= value;
                        end
                        if (last_element)
                        begin
                            gidx_reg  <= '0;
                            state_reg <= ST_CLR;
                        end
                    end
                end
                ST_CLR:
                begin
                    gidx_reg <= gidx_reg + GW'(1);
                    if (gidx_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_E_RD;
                    end
                end
                ST_E_RD: state_reg <= ST_E0;
                ST_E0:   state_reg <= ST_E1;
                ST_E1:
                begin
                    n_reg     <= mul_prod[32:24];
                    f_reg     <= mul_prod[23:8];
                    state_reg <= ST_E2;
                end
                ST_E2:
                begin
                    ff_reg    <= mul_prod[31:16];
                    state_reg <= ST_E3;
                end
                ST_E3:
                begin
                    t1_reg    <= mul_prod[31:16];
                    state_reg <= ST_E4;
                end
                ST_E4:
                begin
                    if (idx_last)
                    begin
                        gidx_reg  <= '0;
                        state_reg <= ST_D_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_E_RD;
                    end
                end
                ST_D_RD: state_reg <= ST_D_GO;
                ST_D_GO: state_reg <= ST_D_WAIT;
                ST_D_WAIT:
                begin
                    if (div_done)
                    begin
                        if (gidx_last)
                        begin
                            idx_reg   <= '0;
                            state_reg <= pass_direction ? ST_B_RD : ST_O_RD;
                        end
                        else
                        begin
                            gidx_reg  <= gidx_reg + GW'(1);
                            state_reg <= ST_D_RD;
                        end
                    end
                end
                ST_B_RD:  state_reg <= ST_B_RD2;
                ST_B_RD2: state_reg <= ST_B1;
                ST_B1:    state_reg <= ST_B2;
                ST_B2:    state_reg <= ST_B3;
                ST_B3:    state_reg <= ST_B4;
                ST_B4:
                begin
                    if (idx_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_O_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_B_RD;
                    end
                end
                ST_O_RD:  state_reg <= ST_O_RD2;
                ST_O_RD2: state_reg <= pass_direction ? ST_OB1 : ST_OF;
                ST_OF:    state_reg <= ST_EMIT;
                ST_OB1:   state_reg <= ST_OB2;
                ST_OB2:   state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    valid_reg <= 1'b1;
                    res_reg   <= mul_sat;
                    last_reg  <= idx_last;
                    if (idx_last)
                    begin
                        cnt_reg   <= '0;
                        max_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_O_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid = valid_reg;
    assign result_value = res_reg;
    assign last_result  = last_reg;

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> state_reg == ST_IDLE && cnt_reg == '0)
        else $error("final item delivered while the run is still active");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |-> busy)
        else $error("non-final item delivered after the run ended");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> cnt_reg != '0)
        else $error("run started with no stored element");

    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_D_WAIT)
        else $error("divider finished outside the reciprocal pass");

endmodule

>>> hw/rtl/grouped_softmax_with_gradient.sv
// Grouped softmax with gradient: top level with configuration register port.
//
// Load a vector with start/busy: an item is taken at a clock edge where start
// is high and busy is low; it carries value, upstream_gradient and group_index
// (folded modulo MAX_GROUPS). Busy stays low while loading, so items may come
// back to back. An item with last_element set raises busy and starts the run:
// a clear sweep over all MAX_GROUPS groups, a pass per element for exp and
// group sums, the serial reciprocal divider per group (one quotient bit per
// cycle), a pass per element for the group gradient sums in backward mode,
// then a pass per element to emit (ST_OF forward, ST_OB1/ST_OB2 backward).
// One item per result appears on result_value for one cycle with result_valid
// high, in load order; last_result marks the final one. The receiver cannot
// stall. The whole run goes through the one shared multiplier and divider.
// pass_direction sits at APB address 0 (0 forward, 1 backward) and is to be
// written only while idle by the user; the block itself does not enforce this.
// Reset empties the store and returns to forward mode.
module grouped_softmax_with_gradient #(
    parameter int MAX_ELEMENTS = gswg_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_GROUPS   = gswg_pkg::MAX_GROUPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gswg_pkg::VAL_W-1:0]   value,
    input  logic signed [gswg_pkg::VAL_W-1:0]   upstream_gradient,
    input  logic [gswg_pkg::GRP_W-1:0]          group_index,
    input  logic                                last_element,
    output logic                                result_valid,
    output logic signed [gswg_pkg::RES_W-1:0]   result_value,
    output logic                                last_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gswg_pkg::ADDR_W-1:0]         paddr,
    input  logic [gswg_pkg::DATA_W-1:0]         pwdata,
    output logic [gswg_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import gswg_pkg::*;

    logic dir_reg;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1] == REG_PASS_DIRECTION;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= 1'b0;
        else if (psel && penable && pwrite && reg_sel)
            dir_reg <= pwdata[0];
    end

    assign prdata = (reg_sel && paddr[1:0] == 2'b00) ? DATA_W'(dir_reg) : '0;

    gswg_core #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_GROUPS   (MAX_GROUPS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .value             (value),
        .upstream_gradient (upstream_gradient),
        .group_index       (group_index),
        .last_element      (last_element),
        .pass_direction    (dir_reg),
        .busy              (busy),
        .result_valid      (result_valid),
        .result_value      (result_value),
        .last_result       (last_result)
    );

endmodule

>>> tb/sv/gswg_checker.sv
// Checker for the grouped softmax block: watches load, result and APB traffic, predicts and compares.
`timescale 1ns / 1ps

module gswg_checker
    import gswg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic signed [VAL_W-1:0] value,
    input  logic signed [VAL_W-1:0] upstream_gradient,
    input  logic [GRP_W-1:0]        group_index,
    input  logic                    last_element,
    input  logic                    result_valid,
    input  logic signed [RES_W-1:0] result_value,
    input  logic                    last_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic                    pready,
    output int                      fail_count,
    output int                      outstanding
);

    localparam int NUM_ELEM = MAX_ELEMENTS_DEF;
    localparam int NUM_GRP  = MAX_GROUPS_DEF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic signed [VAL_W-1:0] value_mem [NUM_ELEM];
    logic signed [VAL_W-1:0] grad_mem  [NUM_ELEM];
    logic [GRP_W-1:0]        grp_mem   [NUM_ELEM];
    int                      loaded;
    logic signed [VAL_W-1:0] peak_value;
    logic                    backward_mode;

    logic signed [RES_W-1:0] want_value_q [$];
    logic                    want_last_q  [$];

    function automatic longint sat_s32(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b, input int sh);
        logic                neg;
        longint unsigned     ua;
        longint unsigned     ub;
        longint unsigned     q;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? longint'(-a) : longint'(a);
        ub  = (b < 0) ? longint'(-b) : longint'(b);
        q   = (ua * ub) >> sh;
        if (neg)
        begin
            if (q > 64'd2147483648) q = 64'd2147483648;
            return -longint'(q);
        end
        if (q > 64'd2147483647) q = 64'd2147483647;
        return longint'(q);
    endfunction

    function automatic longint exp_neg(input longint unsigned m);
        longint unsigned y;
        longint unsigned n;
        longint unsigned f;
        longint unsigned p;
        y = m * 64'd94548;
        n = y >> 24;
        f = (y >> 8) & 64'hFFFF;
        p = 64'd65536 - ((64'd43024 * f) >> 16) + ((64'd10256 * ((f * f) >> 16)) >> 16);
        if (n > 31) return 0;
        return longint'(p >> n);
    endfunction

    task automatic predict_softmax_run();
        longint          e_val [NUM_ELEM];
        longint unsigned sums  [NUM_GRP];
        longint          recip [NUM_GRP];
        longint          gsum  [NUM_GRP];
        longint          r;
        longint          t;
        longint          inner;
        longint          res;
        for (int k = 0; k < NUM_GRP; k++)
        begin
            sums[k] = 0;
            gsum[k] = 0;
        end
        for (int i = 0; i < loaded; i++)
        begin
            e_val[i] = exp_neg(longint'(int'(peak_value) - int'(value_mem[i])));
            sums[grp_mem[i]] += longint'(e_val[i]);
        end
        for (int k = 0; k < NUM_GRP; k++)
            recip[k] = longint'((64'd1 << 32) / (sums[k] + 64'd7));
        if (backward_mode)
        begin
            for (int i = 0; i < loaded; i++)
            begin
                r = recip[grp_mem[i]];
                t = fixed_mul(fixed_mul(fixed_mul(longint'(grad_mem[i]), e_val[i], 8), r, 16),
                              r, 16);
                gsum[grp_mem[i]] = sat_s32(gsum[grp_mem[i]] - t);
            end
        end
        for (int i = 0; i < loaded; i++)
        begin
            r = recip[grp_mem[i]];
            if (backward_mode)
            begin
                inner = sat_s32(gsum[grp_mem[i]] + fixed_mul(longint'(grad_mem[i]), r, 8));
                res   = fixed_mul(e_val[i], inner, 16);
            end
            else
                res = fixed_mul(e_val[i], r, 16);
            want_value_q.push_back(res[31:0]);
            want_last_q.push_back(i + 1 == loaded);
        end
        loaded     = 0;
        peak_value = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded        = 0;
            peak_value    = '0;
            backward_mode = 1'b0;
            fail_count    = 0;
            outstanding   = 0;
            want_value_q.delete();
            want_last_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_PASS_DIRECTION)
                backward_mode = pwdata[0];
            if (result_valid)
            begin
                if (want_value_q.size() == 0)
                begin
                    $error("unexpected result: result_value=%0d last_result=%0b",
                           result_value, last_result);
                    fail_count++;
                end
                else
                begin
                    if (result_value !== want_value_q[0])
                    begin
                        $error("result_value: expected %0d, actual %0d",
                               want_value_q[0], result_value);
                        fail_count++;
                    end
                    if (last_result !== want_last_q[0])
                    begin
                        $error("last_result: expected %0b, actual %0b",
                               want_last_q[0], last_result);
                        fail_count++;
                    end
                    void'(want_value_q.pop_front());
                    void'(want_last_q.pop_front());
                end
            end
            if (start && !busy)
            begin
                if (loaded < NUM_ELEM)
                begin
                    value_mem[loaded] = value;
                    grad_mem[loaded]  = upstream_gradient;
                    grp_mem[loaded]   = GRP_W'(group_index % NUM_GRP);
                    loaded++;
                    if (value > peak_value) peak_value = value;
                end
                if (last_element) predict_softmax_run();
            end
            outstanding = want_value_q.size();
        end
    end

endmodule

>>> tb/sv/tb_grouped_softmax_with_gradient.sv
// Testbench top for the grouped softmax block: clock, reset, load and APB stimulus, verdict.
`timescale 1ns / 1ps

module tb_grouped_softmax_with_gradient;
    import gswg_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] upstream_gradient;
    logic [GRP_W-1:0]        group_index;
    logic                    last_element;
    logic                    result_valid;
    logic signed [RES_W-1:0] result_value;
    logic                    last_result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    int                      fail_count;
    int                      outstanding;
    int                      cycle_count;
    int                      items_sent;

    grouped_softmax_with_gradient i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .value(value), .upstream_gradient(upstream_gradient),
        .group_index(group_index), .last_element(last_element),
        .result_valid(result_valid), .result_value(result_value), .last_result(last_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    gswg_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .value(value), .upstream_gradient(upstream_gradient),
        .group_index(group_index), .last_element(last_element),
        .result_valid(result_valid), .result_value(result_value), .last_result(last_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic signed [VAL_W-1:0] g,
                             input logic [GRP_W-1:0] grp, input logic last);
        value             <= v;
        upstream_gradient <= g;
        group_index       <= grp;
        last_element      <= last;
        start             <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic pause_load();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80) : $urandom_range(0, 2);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic dir);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(4 * REG_PASS_DIRECTION);
        pwdata  <= {31'd0, dir};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_vector(input int len, input int grp_span, input logic tight);
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W-1:0] g;
        logic [GRP_W-1:0]        grp;
        base = VAL_W'($urandom);
        for (int i = 0; i < len; i++)
        begin
            v   = tight ? VAL_W'(base + $urandom_range(0, 2047) - 1024) : VAL_W'($urandom);
            g   = ($urandom_range(0, 1) == 0) ? VAL_W'($urandom_range(0, 1023) - 512)
                                              : VAL_W'($urandom);
            grp = ($urandom_range(0, 3) == 0) ? GRP_W'($urandom) : GRP_W'($urandom_range(0, grp_span));
            send_item(v, g, grp, i == len - 1);
            pause_load();
        end
    endtask

    task automatic directed_phase();
        send_item(16'sd32767, 16'sd32767, 6'd0, 1'b0);
        send_item(-16'sd32768, -16'sd32768, 6'd63, 1'b0);
        send_item(16'sd0, 16'sd0, 6'd0, 1'b0);
        send_item(16'sd256, -16'sd256, 6'd42, 1'b0);
        send_item(-16'sd1, 16'sd1, 6'd21, 1'b1);
        pause_load();
        send_item(16'sd100, 16'sd512, 6'd5, 1'b1);
        pause_load();
        send_item(-16'sd5000, 16'sd300, 6'd1, 1'b0);
        send_item(-16'sd5000, -16'sd300, 6'd1, 1'b0);
        send_item(-16'sd4000, 16'sd32767, 6'd2, 1'b1);
        pause_load();
    endtask

    initial
    begin
        cycle_count       = 0;
        items_sent        = 0;
        rst_n             = 1'b0;
        start             = 1'b0;
        value             = '0;
        upstream_gradient = '0;
        group_index       = '0;
        last_element      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_phase();
        wait_idle();
        write_direction(1'b1);
        directed_phase();
        wait_idle();
        // store-full vector: drop items beyond capacity
        send_vector(MAX_ELEMENTS_DEF + 2, 7, 1'b1);
        wait_idle();

        while (items_sent < 100)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_direction(1'($urandom_range(0, 1)));
            end
            send_vector(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                    : $urandom_range(1, 8),
                        ($urandom_range(0, 1) == 0) ? 3 : 63,
                        $urandom_range(0, 2) != 0);
        end
        wait_idle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> grouped_softmax_with_gradient.f
hw/rtl/gswg_pkg.sv
hw/rtl/gswg_mul.sv
hw/rtl/gswg_div.sv
hw/rtl/gswg_core.sv
hw/rtl/grouped_softmax_with_gradient.sv
tb/sv/gswg_checker.sv
tb/sv/tb_grouped_softmax_with_gradient.sv
